### src/assert_macros.svh
// Assertion helpers, clocked on clk and disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication check: when ante holds, cons must hold in the same cycle.
`define PCX_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Plain invariant.
`define PCX_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

### src/pcxrle_pkg.sv
package pcxrle_pkg;

  localparam int MAX_WIDTH_DEF  = 320;
  localparam int MAX_HEIGHT_DEF = 256;
  localparam int PALETTE_SIZE   = 256;

  localparam int SIZE_W    = 9;
  localparam int RUN_W     = 6;
  localparam int CFG_IDX_W = 2;
  localparam int COLOR_W   = 24;
  localparam int COL_OUT_W = 9;
  localparam int ROW_OUT_W = 8;

  localparam logic [SIZE_W-1:0] WIDTH_RESET  = 9'd320;
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = 9'd200;

  // Request codes on the input channel
  localparam logic [1:0] REQ_PAL     = 2'd0;
  localparam logic [1:0] REQ_DATA    = 2'd1;
  localparam logic [1:0] REQ_RESTART = 2'd2;

  // Register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

  // Run header: top two bits set
  localparam logic [1:0] RUN_MARK = 2'b11;

  // Command queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_PAL     = 2'd0,
    CMD_DATA    = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t            kind;
    logic                 run_hdr;
    logic [7:0]           data_byte;
    logic [7:0]           pal_index;
    logic [COLOR_W-1:0]   pal_color;
  } cmd_t;

endpackage

### src/pcxrle_front.sv
module pcxrle_front (
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_req_type,
  input  logic [7:0]           in_palette_index,
  input  logic [23:0]          in_palette_color,
  input  logic [7:0]           in_data_byte,
  input  logic                 q_full,
  output logic                 q_push,
  output pcxrle_pkg::cmd_t     q_cmd
);
  import pcxrle_pkg::*;

  logic known;

  assign in_ready = !q_full;

  // Unused request code is taken and dropped
  always_comb begin
    known          = 1'b1;
    q_cmd.kind     = CMD_DATA;
    q_cmd.run_hdr  = (in_data_byte[7:6] == RUN_MARK);
    q_cmd.data_byte = in_data_byte;
    q_cmd.pal_index = in_palette_index;
    q_cmd.pal_color = in_palette_color;
    unique case (in_req_type)
      REQ_PAL:     q_cmd.kind = CMD_PAL;
      REQ_DATA:    q_cmd.kind = CMD_DATA;
      REQ_RESTART: q_cmd.kind = CMD_RESTART;
      default:     known = 1'b0;
    endcase
  end

  assign q_push = in_valid && in_ready && known;

endmodule

### src/pcxrle_cmdq.sv
module pcxrle_cmdq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  pcxrle_pkg::cmd_t  push_cmd,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output pcxrle_pkg::cmd_t  head
);
  import pcxrle_pkg::*;

  cmd_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

### src/pcxrle_back.sv
module pcxrle_back #(
  parameter int MAX_WIDTH  = pcxrle_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = pcxrle_pkg::MAX_HEIGHT_DEF,
  parameter int CW         = $clog2(MAX_WIDTH + 1),
  parameter int RW         = $clog2(MAX_HEIGHT + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cmd_valid,
  input  pcxrle_pkg::cmd_t             cmd,
  output logic                         cmd_pop,
  input  logic                         restart,
  input  logic [CW-1:0]                w_size,
  input  logic [RW-1:0]                h_size,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [7:0]                   out_red,
  output logic [7:0]                   out_green,
  output logic [7:0]                   out_blue,
  output logic [pcxrle_pkg::COL_OUT_W-1:0] out_column,
  output logic [pcxrle_pkg::ROW_OUT_W-1:0] out_row,
  output logic                         out_run_end,
  output logic                         out_image_end
);
  import pcxrle_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;
  localparam int   MW      = (CW > RUN_W) ? CW : RUN_W;

  logic               state_r, state_nxt;
  logic               pend_r, pend_nxt;
  logic [RUN_W-1:0]   pend_cnt_r, pend_cnt_nxt;
  logic [RUN_W-1:0]   rem_r, rem_nxt;
  logic [CW-1:0]      col_r, col_nxt;
  logic [RW-1:0]      row_r, row_nxt;
  logic               done_r, done_nxt;

  logic [COLOR_W-1:0] pal_mem [PALETTE_SIZE];
  logic [COLOR_W-1:0] pal_rd_r;
  logic               pal_we, pal_re;

  logic               ovalid_r, ovalid_nxt;
  logic [COLOR_W-1:0] ocolor_r;
  logic [COL_OUT_W-1:0] ocol_r;
  logic [ROW_OUT_W-1:0] orow_r;
  logic               orun_end_r, oimg_end_r;

  logic               slot_free, load;
  logic               start;
  logic [RUN_W-1:0]   start_cnt;
  logic [MW-1:0]      room;
  logic               last_px, wrap, last_row;

  assign slot_free = !ovalid_r || out_ready;
  assign cmd_pop   = cmd_valid && (state_r == ST_IDLE);
  assign room      = MW'(w_size) - MW'(col_r);
  assign last_px   = (rem_r == RUN_W'(1));
  assign wrap      = ((CW+1)'(col_r) + (CW+1)'(1)) == (CW+1)'(w_size);
  assign last_row  = ((RW+1)'(row_r) + (RW+1)'(1)) >= (RW+1)'(h_size);
  assign load      = (state_r == ST_EMIT) && slot_free;
  assign pal_we    = cmd_pop && (cmd.kind == CMD_PAL);
  assign pal_re    = start;

  // Dispatch: classify the queued command against the decode state, step the emit loop, apply a size restart
  always_comb begin
    state_nxt    = state_r;
    pend_nxt     = pend_r;
    pend_cnt_nxt = pend_cnt_r;
    rem_nxt      = rem_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    done_nxt     = done_r;
    start        = 1'b0;
    start_cnt    = RUN_W'(1);

    if (cmd_pop) begin
      unique case (cmd.kind)
        CMD_PAL: ;
        CMD_RESTART: begin
          pend_nxt     = 1'b0;
          pend_cnt_nxt = '0;
          col_nxt      = '0;
          row_nxt      = '0;
          done_nxt     = 1'b0;
        end
        CMD_DATA: begin
          if (!done_r) begin
            if (pend_r) begin
              pend_nxt     = 1'b0;
              pend_cnt_nxt = '0;
              start_cnt    = pend_cnt_r;
              start        = (pend_cnt_r != '0);
            end else if (cmd.run_hdr) begin
              pend_nxt     = 1'b1;
              pend_cnt_nxt = cmd.data_byte[RUN_W-1:0];
            end else begin
              start = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end

    if (start) begin
      // clip to the room left in this row
      rem_nxt   = (MW'(start_cnt) < room) ? start_cnt : RUN_W'(room);
      state_nxt = ST_EMIT;
    end

    if (load) begin
      rem_nxt = rem_r - RUN_W'(1);
      if (wrap) begin
        col_nxt = '0;
        if (last_row) begin
          done_nxt = 1'b1;
        end else begin
          row_nxt = row_r + RW'(1);
        end
      end else begin
        col_nxt = col_r + CW'(1);
      end
      if (last_px) begin
        state_nxt = ST_IDLE;
      end
    end

    // size register write; the user must write it only while the block is idle, the block does not enforce it
    if (restart) begin
      pend_nxt     = 1'b0;
      pend_cnt_nxt = '0;
      col_nxt      = '0;
      row_nxt      = '0;
      done_nxt     = 1'b0;
    end
  end

  always_comb begin
    ovalid_nxt = ovalid_r;
    if (load) begin
      ovalid_nxt = 1'b1;
    end else if (out_ready) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      pend_r     <= 1'b0;
      pend_cnt_r <= '0;
      rem_r      <= '0;
      col_r      <= '0;
      row_r      <= '0;
      done_r     <= 1'b0;
      ovalid_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      pend_r     <= pend_nxt;
      pend_cnt_r <= pend_cnt_nxt;
      rem_r      <= rem_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      done_r     <= done_nxt;
      ovalid_r   <= ovalid_nxt;
    end
  end

  // Palette RAM, registered read
  always_ff @(posedge clk) begin
    if (pal_we) begin
      pal_mem[cmd.pal_index] <= cmd.pal_color;
    end
    if (pal_re) begin
      pal_rd_r <= pal_mem[cmd.data_byte];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ocolor_r   <= pal_rd_r;
      ocol_r     <= COL_OUT_W'(col_r);
      orow_r     <= ROW_OUT_W'(row_r);
      orun_end_r <= last_px;
      oimg_end_r <= last_px && wrap && last_row;
    end
  end

  assign out_valid     = ovalid_r;
  assign out_red       = ocolor_r[23:16];
  assign out_green     = ocolor_r[15:8];
  assign out_blue      = ocolor_r[7:0];
  assign out_column    = ocol_r;
  assign out_row       = orow_r;
  assign out_run_end   = orun_end_r;
  assign out_image_end = oimg_end_r;

endmodule

### src/pcx_rle_palette_decoder.sv
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_ready  | req_type, palette_index, palette_color, data_byte
// cfg     | input     | cfg_valid/cfg_ready| cfg_index (0 width, 1 height), cfg_data
// out     | output    | out_valid/out_ready| red, green, blue, column, row, run_end, image_end
//
// Steps: palette write, restart and run header are handled as the command is popped; a pixel
//   byte starts the back end's emit loop behind the registered palette RAM read, which gives
//   one pixel per cycle while out_ready does not stall it.
// Reset: rst_n synchronous, active low; palette RAM is not cleared; cfg_ready stays high.
// Stalls: the front takes a transaction while the 2-entry command queue has room;
//   out_ready low holds the output register and the emit loop, then in_ready drops.
module pcx_rle_palette_decoder #(
  parameter int MAX_WIDTH  = pcxrle_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = pcxrle_pkg::MAX_HEIGHT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_req_type,
  input  logic [7:0]                        in_palette_index,
  input  logic [23:0]                       in_palette_color,
  input  logic [7:0]                        in_data_byte,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pcxrle_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pcxrle_pkg::SIZE_W-1:0]     cfg_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [7:0]                        out_red,
  output logic [7:0]                        out_green,
  output logic [7:0]                        out_blue,
  output logic [pcxrle_pkg::COL_OUT_W-1:0]  out_column,
  output logic [pcxrle_pkg::ROW_OUT_W-1:0]  out_row,
  output logic                              out_run_end,
  output logic                              out_image_end
);
  import pcxrle_pkg::*;
  `include "assert_macros.svh"

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 1);

  // Size registers, kept raw; clamped when used
  logic [SIZE_W-1:0] width_r, width_nxt;
  logic [SIZE_W-1:0] height_r, height_nxt;
  logic              cfg_wr, size_restart;
  logic [CW-1:0]     w_size;
  logic [RW-1:0]     h_size;

  // Front to queue to back
  logic  q_push, q_full, q_pop, q_not_empty;
  cmd_t  q_cmd, q_head;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_comb begin
    width_nxt    = width_r;
    height_nxt   = height_r;
    size_restart = 1'b0;
    if (cfg_wr) begin
      priority if (cfg_index == REG_WIDTH) begin
        width_nxt    = cfg_data;
        size_restart = 1'b1;
      end else if (cfg_index == REG_HEIGHT) begin
        height_nxt   = cfg_data;
        size_restart = 1'b1;
      end else begin
        // unknown index: dropped
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  // Saturate to 1..MAX
  always_comb begin
    if (width_r == '0) begin
      w_size = CW'(1);
    end else if (32'(width_r) > 32'(MAX_WIDTH)) begin
      w_size = CW'(MAX_WIDTH);
    end else begin
      w_size = CW'(width_r);
    end
    if (height_r == '0) begin
      h_size = RW'(1);
    end else if (32'(height_r) > 32'(MAX_HEIGHT)) begin
      h_size = RW'(MAX_HEIGHT);
    end else begin
      h_size = RW'(height_r);
    end
  end

  pcxrle_front u_front (
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_palette_index (in_palette_index),
    .in_palette_color (in_palette_color),
    .in_data_byte     (in_data_byte),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_cmd            (q_cmd)
  );

  pcxrle_cmdq u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (q_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  pcxrle_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .CW         (CW),
    .RW         (RW)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (q_not_empty),
    .cmd           (q_head),
    .cmd_pop       (q_pop),
    .restart       (size_restart),
    .w_size        (w_size),
    .h_size        (h_size),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_column    (out_column),
    .out_row       (out_row),
    .out_run_end   (out_run_end),
    .out_image_end (out_image_end)
  );

  // The last pixel of the image always closes its run.
  `PCX_ASSERT_IMPL(a_img_end, out_valid && out_image_end, out_run_end, "image_end w/o run_end")
  // Queue never written when full nor read when empty.
  `PCX_ASSERT_NEVER(a_q_overflow, q_push && q_full, "command queue overflow")
  `PCX_ASSERT_NEVER(a_q_underflow, q_pop && !q_not_empty, "command queue underflow")

endmodule
